// ===== design/smct_pkg.sv =====
// ----------------------------------------------------------------------------
// smct_pkg: shared types and constants
// Word formats, opcodes, controller states and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package smct_pkg;

	localparam logic [2:0] OP_CLEAR   = 3'd0;
	localparam logic [2:0] OP_APPEND  = 3'd1;
	localparam logic [2:0] OP_CONTAIN = 3'd2;
	localparam logic [2:0] OP_EXTEND  = 3'd3;
	localparam logic [2:0] OP_DUMP    = 3'd4;

	localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] probe_start;
		logic [31:0] target_start;
		logic [15:0] length;
		logic [15:0] identities;
		logic [7:0]  match_mode;
	} in_t;

	typedef struct packed {
		logic        status;
		logic        hit;
		logic [31:0] out_probe_start;
		logic [31:0] out_target_start;
		logic [15:0] out_length;
		logic [15:0] out_identities;
		logic [7:0]  out_mode;
		logic        entry_present;
		logic        last;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FIND,
		ST_LRD,
		ST_DRD,
		ST_EVAL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic clear;
		logic find_init;
		logic find_step;
		logic append_wr;
		logic scan_init;
		logic list_rd;
		logic data_rd;
		logic eval;
		logic load_single;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       full;
		logic       remain_last;
		logic       find_free;
		logic       out_ready;
	} status_t;

endpackage

// ===== design/smct_ctrl.sv =====
// ----------------------------------------------------------------------------
// smct_ctrl: sequencing controller
// Steps each opcode through dispatch, free-slot search, the per-entry
// list read / data read / evaluate loop, and the final result word.
// ----------------------------------------------------------------------------
module smct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  smct_pkg::status_t  sts,
	output smct_pkg::cmd_t     cmd
);

	smct_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != smct_pkg::ST_IDLE);
		unique case (state_q)
			smct_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = smct_pkg::ST_DISPATCH;
				end
			end
			smct_pkg::ST_DISPATCH: begin
				cmd.prep = 1'b1;
				priority if (sts.op == smct_pkg::OP_CLEAR) begin
					cmd.clear = 1'b1;
					state_d   = smct_pkg::ST_FIN;
				end else if (sts.op == smct_pkg::OP_APPEND) begin
					if (sts.full) begin
						state_d = smct_pkg::ST_FIN;
					end else begin
						cmd.find_init = 1'b1;
						state_d       = smct_pkg::ST_FIND;
					end
				end else if (sts.op == smct_pkg::OP_CONTAIN || sts.op == smct_pkg::OP_EXTEND
						|| sts.op == smct_pkg::OP_DUMP) begin
					if (sts.empty) begin
						state_d = smct_pkg::ST_FIN;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = smct_pkg::ST_LRD;
					end
				end else begin
					state_d = smct_pkg::ST_FIN;
				end
			end
			smct_pkg::ST_FIND: begin
				if (sts.find_free) begin
					cmd.append_wr = 1'b1;
					state_d       = smct_pkg::ST_FIN;
				end else begin
					cmd.find_step = 1'b1;
				end
			end
			smct_pkg::ST_LRD: begin
				cmd.list_rd = 1'b1;
				state_d     = smct_pkg::ST_DRD;
			end
			smct_pkg::ST_DRD: begin
				cmd.data_rd = 1'b1;
				state_d     = smct_pkg::ST_EVAL;
			end
			smct_pkg::ST_EVAL: begin
				// a dump word needs room in the output register
				if (sts.op != smct_pkg::OP_DUMP || sts.out_ready) begin
					cmd.eval = 1'b1;
					if (!sts.remain_last) begin
						state_d = smct_pkg::ST_LRD;
					end else if (sts.op == smct_pkg::OP_DUMP) begin
						state_d = smct_pkg::ST_IDLE;
					end else begin
						state_d = smct_pkg::ST_FIN;
					end
				end
			end
			smct_pkg::ST_FIN: begin
				if (sts.out_ready) begin
					cmd.load_single = 1'b1;
					state_d         = smct_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = smct_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/smct_dp.sv =====
// ----------------------------------------------------------------------------
// smct_dp: match table datapath
// Entry memories, valid bits, a circular age-order list of occupied slots
// (oldest at head), span comparators and the output register.
// ----------------------------------------------------------------------------
module smct_dp #(
	parameter int MAX_MATCHES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smct_pkg::cmd_t     cmd,
	input  smct_pkg::in_t      in_data,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               out_stall,
	output smct_pkg::status_t  sts,
	output logic               out_valid,
	output smct_pkg::out_t     out_data
);

	localparam int PW = $clog2(MAX_MATCHES);
	localparam int CW = $clog2(MAX_MATCHES + 1);
	localparam logic [PW:0]   MAXW = (PW + 1)'(MAX_MATCHES);
	localparam logic [PW-1:0] TOP  = PW'(MAX_MATCHES - 1);

	// entry stores
	logic [31:0]   ps_mem   [MAX_MATCHES];
	logic [31:0]   ts_mem   [MAX_MATCHES];
	logic [15:0]   len_mem  [MAX_MATCHES];
	logic [15:0]   id_mem   [MAX_MATCHES];
	logic [7:0]    mode_mem [MAX_MATCHES];
	logic [PW-1:0] list_mem [MAX_MATCHES];

	logic [MAX_MATCHES-1:0] valid_q;
	logic [PW-1:0] head_q, r_q, w_q, f_q;
	logic [CW-1:0] cnt_q, rem_q, k_q;
	logic [15:0]   max_len_q;
	logic          hit_q, done_q, rewr_q, full_q, out_valid_q;

	// captured word
	logic [2:0]  op_q;
	logic [31:0] ps_q, ts_q, pe_q, te_q;
	logic [15:0] len_q, id_q;
	logic [7:0]  mode_q;

	// read-back of one entry
	logic [PW-1:0] slot_q;
	logic [31:0]   d_ps_q, d_ts_q;
	logic [15:0]   d_len_q, d_id_q;
	logic [7:0]    d_mode_q;

	smct_pkg::out_t out_q;
	smct_pkg::out_t dump_word, single_word;

	logic [PW:0]   tail_sum, new_sum;
	logic [PW-1:0] tail, newest, w_dec, w_inc;
	logic [15:0]   len_clamp;
	logic [31:0]   spe, ste;
	logic          mode_eq, active, is_in, holds, shared;
	logic          is_con, is_ext, is_dump;
	logic          ev_hit_in, ev_rew_c, ev_free, ev_shared, ev_rew_e, keep;
	logic          out_ready;

	assign tail_sum  = (PW + 1)'(head_q) + (PW + 1)'(cnt_q);
	assign tail      = (tail_sum >= MAXW) ? PW'(tail_sum - MAXW) : PW'(tail_sum);
	assign new_sum   = tail_sum - (PW + 1)'(1);
	assign newest    = (new_sum >= MAXW) ? PW'(new_sum - MAXW) : PW'(new_sum);
	assign w_dec     = (w_q == '0) ? TOP : w_q - PW'(1);
	assign w_inc     = (w_q == TOP) ? '0 : w_q + PW'(1);
	assign len_clamp = (in_data.length > max_len_q) ? max_len_q : in_data.length;

	assign spe     = d_ps_q + 32'(d_len_q) - 32'd1;
	assign ste     = d_ts_q + 32'(d_len_q) - 32'd1;
	assign mode_eq = (d_mode_q == mode_q);
	assign active  = !done_q && mode_eq;
	assign is_in   = (ps_q >= d_ps_q) && (pe_q <= spe) && (ts_q >= d_ts_q) && (te_q <= ste);
	assign holds   = (ps_q <= d_ps_q) && (pe_q >= spe) && (ts_q <= d_ts_q) && (te_q >= ste);
	assign shared  = ((ps_q == d_ps_q) && (ts_q == d_ts_q)) || ((pe_q == spe) && (te_q == ste));
	assign is_con  = (op_q == smct_pkg::OP_CONTAIN);
	assign is_ext  = (op_q == smct_pkg::OP_EXTEND);
	assign is_dump = (op_q == smct_pkg::OP_DUMP);

	assign ev_hit_in = (is_con || is_ext) && active && is_in;
	assign ev_rew_c  = is_con && active && !is_in && holds && !rewr_q;
	assign ev_free   = is_con && active && !is_in && holds && rewr_q;
	assign ev_shared = is_ext && active && !is_in && shared;
	assign ev_rew_e  = ev_shared && (len_q > d_len_q);
	assign keep      = !ev_free;

	assign out_ready = !out_valid_q || !out_stall;

	assign sts.op          = op_q;
	assign sts.empty       = (cnt_q == '0);
	assign sts.full        = full_q;
	assign sts.remain_last = (rem_q == CW'(1));
	assign sts.find_free   = !valid_q[f_q];
	assign sts.out_ready   = out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		dump_word                  = '0;
		dump_word.out_probe_start  = d_ps_q;
		dump_word.out_target_start = d_ts_q;
		dump_word.out_length       = d_len_q;
		dump_word.out_identities   = d_id_q;
		dump_word.out_mode         = d_mode_q;
		dump_word.entry_present    = 1'b1;
		dump_word.last             = sts.remain_last;
		single_word                = '0;
		single_word.status         = full_q && (op_q == smct_pkg::OP_APPEND);
		single_word.hit            = hit_q;
		single_word.last           = 1'b1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
			k_q         <= '0;
			r_q         <= '0;
			w_q         <= '0;
			f_q         <= '0;
			max_len_q   <= smct_pkg::MAX_LEN_RESET;
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
			rewr_q      <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
			if (cmd.capture) begin
				hit_q  <= 1'b0;
				done_q <= 1'b0;
				rewr_q <= 1'b0;
				full_q <= (cnt_q == CW'(MAX_MATCHES));
			end
			if (cmd.clear) begin
				valid_q <= '0;
				head_q  <= '0;
				cnt_q   <= '0;
			end
			if (cmd.find_init) begin
				f_q <= '0;
			end
			if (cmd.find_step) begin
				f_q <= f_q + PW'(1);
			end
			if (cmd.append_wr) begin
				valid_q[f_q] <= 1'b1;
				cnt_q        <= cnt_q + CW'(1);
			end
			if (cmd.scan_init) begin
				r_q   <= newest;
				w_q   <= newest;
				rem_q <= cnt_q;
				k_q   <= '0;
			end
			if (cmd.list_rd) begin
				r_q <= (r_q == '0) ? TOP : r_q - PW'(1);
			end
			if (cmd.eval) begin
				rem_q <= rem_q - CW'(1);
				if (keep) begin
					w_q <= w_dec;
					k_q <= k_q + CW'(1);
				end
				if (ev_free) begin
					valid_q[slot_q] <= 1'b0;
				end
				if (ev_hit_in || ev_rew_c || ev_shared) begin
					hit_q <= 1'b1;
				end
				if (ev_hit_in || ev_shared) begin
					done_q <= 1'b1;
				end
				if (ev_rew_c) begin
					rewr_q <= 1'b1;
				end
				// compacted list: kept slots end at the last written position
				if (sts.remain_last) begin
					cnt_q  <= k_q + CW'(keep);
					head_q <= keep ? w_q : w_inc;
				end
			end
			if (cmd.load_single || (cmd.eval && is_dump)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and memories
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_data.opcode;
			ps_q   <= in_data.probe_start;
			ts_q   <= in_data.target_start;
			len_q  <= len_clamp;
			id_q   <= in_data.identities;
			mode_q <= in_data.match_mode;
		end
		if (cmd.prep) begin
			pe_q <= ps_q + 32'(len_q) - 32'd1;
			te_q <= ts_q + 32'(len_q) - 32'd1;
		end
		if (cmd.append_wr) begin
			ps_mem[f_q]     <= ps_q;
			ts_mem[f_q]     <= ts_q;
			len_mem[f_q]    <= len_q;
			id_mem[f_q]     <= id_q;
			mode_mem[f_q]   <= mode_q;
			list_mem[tail]  <= f_q;
		end
		if (cmd.list_rd) begin
			slot_q <= list_mem[r_q];
		end
		if (cmd.data_rd) begin
			d_ps_q   <= ps_mem[slot_q];
			d_ts_q   <= ts_mem[slot_q];
			d_len_q  <= len_mem[slot_q];
			d_id_q   <= id_mem[slot_q];
			d_mode_q <= mode_mem[slot_q];
		end
		if (cmd.eval) begin
			if (keep) begin
				list_mem[w_q] <= slot_q;
			end
			if (ev_rew_c || ev_rew_e) begin
				ps_mem[slot_q]  <= ps_q;
				ts_mem[slot_q]  <= ts_q;
				len_mem[slot_q] <= len_q;
			end
			if (ev_rew_e) begin
				id_mem[slot_q] <= id_q;
			end
		end
		if (cmd.eval && is_dump) begin
			out_q <= dump_word;
		end else if (cmd.load_single) begin
			out_q <= single_word;
		end
	end

endmodule

// ===== design/seed_match_containment_table.sv =====
// ----------------------------------------------------------------------------
// seed_match_containment_table: match table with containment checks
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_stall stays high until its work is done.
// Clear and undefined opcodes go straight from dispatch to the result word;
// append first searches the valid bits for the lowest free slot, from slot
// zero up, or skips the search when the table is full. Containment,
// near-extend and dump walk the occupied entries newest first through an
// age-order list, each entry in turn through list memory read, entry memory
// read and compare; dump entries also wait on out_stall. No clearing pass
// after reset.
module seed_match_containment_table #(
	parameter int MAX_MATCHES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  smct_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output smct_pkg::out_t  out_data,
	input  logic            cfg_wr_en,
	input  logic [15:0]     cfg_wr_data
);

	smct_pkg::cmd_t    cmd;
	smct_pkg::status_t sts;

	smct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	smct_dp #(
		.MAX_MATCHES (MAX_MATCHES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_stall   (out_stall),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule

// ===== design/smct_checker.sv =====
// ----------------------------------------------------------------------------
// smct_checker: port-level checks
// Watches the top-level ports of the match table; bound to the top level.
// ----------------------------------------------------------------------------
module smct_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input smct_pkg::out_t  out_data
);

	// a stalled result word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again without a busy cycle");

	// only dump entries are non-final
	a_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.entry_present)
		else $error("non-final word without an entry");

	// dump entries carry no status or hit
	a_entry_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.entry_present |-> !out_data.hit && !out_data.status)
		else $error("dump entry with status or hit set");

endmodule

bind seed_match_containment_table smct_checker u_smct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
